// ===== src/amap_pkg.sv =====
// Types and constants shared by the MADT local APIC ID parser and its channels.
package amap_pkg;

	// Result kinds
	typedef enum logic {
		KIND_ID      = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	// Summary status codes
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD_SIG = 2'd1,
		STAT_BAD_SUM = 2'd2,
		STAT_SHORT   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] table_byte;
		logic       first;
	} byte_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  apic_id;
		logic [8:0]  id_count;
		status_t     status;
		logic [31:0] apic_base;
		logic        last;
	} result_item_t;

	// "APIC", byte 0 in the low lane
	localparam logic [3:0][7:0] SigBytes = {8'h43, 8'h49, 8'h50, 8'h41};

	localparam logic [31:0] HeaderEnd    = 32'd44;
	localparam logic [31:0] LenFieldEnd  = 32'd7;
	localparam logic [31:0] LenFieldBeg  = 32'd4;
	localparam logic [31:0] AddrFieldBeg = 32'd36;
	localparam logic [31:0] AddrFieldEnd = 32'd40;
	localparam logic [7:0]  MinRecord    = 8'd2;
	localparam logic [7:0]  MinCpuRecord = 8'd8;
	localparam logic [7:0]  LapicType    = 8'd0;
	localparam logic [1:0]  UsableMask   = 2'b11;
	localparam logic [8:0]  MaxIds       = 9'd256;

	// Record byte offsets of interest
	localparam logic [7:0] RecIdxType  = 8'd0;
	localparam logic [7:0] RecIdxLen   = 8'd1;
	localparam logic [7:0] RecIdxId    = 8'd3;
	localparam logic [7:0] RecIdxFlags = 8'd4;

	// Result queue depth
	localparam int FifoDepth = 4;

endpackage

// ===== src/amap_byte_if.sv =====
// Table byte channel: valid/ready handshake with one byte item as payload.
interface amap_byte_if
	import amap_pkg::*;
();
	logic       valid;
	logic       ready;
	byte_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/amap_result_if.sv =====
// Result channel: valid/ready handshake with one result item as payload.
interface amap_result_if
	import amap_pkg::*;
();
	logic         valid;
	logic         ready;
	result_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/acpi_madt_apic_id_parser_core.sv =====
// MADT parser top level: header checks, record walk, ID and summary results.
//
//  channel    | dir | payload
//  -----------+-----+----------------------------------------------------
//  tbl_bytes  | in  | table_byte, first
//  results    | out | kind, apic_id, id_count, status, apic_base, last
//
// One byte is taken per cycle while input ready is high; a byte enters an input register,
// the parse state and up to two results are formed from it the next cycle, and results
// leave through a four-entry result queue, one transfer per cycle while the receiver is ready.
// A byte's results pass through the input register and then the result queue.
// Input ready drops only while the queue may lack room for two more results.
// arst_n clears the parse state, the input stage valid bit and the queue pointers and count.
module acpi_madt_apic_id_parser_core
	import amap_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	amap_byte_if.sink            tbl_bytes,
	amap_result_if.source        results
);

	localparam int PtrW = $clog2(FifoDepth);
	localparam int CntW = $clog2(FifoDepth + 1);

	// input stage
	logic       valid_s1;
	byte_item_t item_s1;

	// parse state
	logic [31:0] pos_q, len_q, lapic_q, next_off_q;
	logic [7:0]  sum_q, ridx_q, rlen_q, rtype_q, rid_q;
	logic        sig_ok_q, rusable_q, walk_q, done_q;
	logic [8:0]  ids_q;

	logic [31:0] eff_pos, eff_len, eff_lapic, eff_next;
	logic [7:0]  eff_sum, eff_ridx, eff_rlen, eff_rtype, eff_rid;
	logic        eff_sig, eff_rusable, eff_walk, eff_done;
	logic [8:0]  eff_ids;

	logic [31:0] nxt_pos, nxt_len, nxt_lapic, nxt_next;
	logic [7:0]  nxt_sum, nxt_ridx, nxt_rlen, nxt_rtype, nxt_rid;
	logic        nxt_sig, nxt_rusable, nxt_walk, nxt_done;
	logic [8:0]  nxt_ids;

	logic         id_hit, end_hit, rec_ok;
	logic [7:0]   b;
	logic [32:0]  start33;
	status_t      stat;
	result_item_t id_res, sum_res, res_a, res_b;
	logic [1:0]   push_n;

	// result queue
	result_item_t      mem [FifoDepth];
	logic [PtrW-1:0]   wp_q, rp_q;
	logic [CntW-1:0]   cnt_q;
	logic              pop, accept;
	logic [CntW+1:0]   room_need;

	assign room_need = {2'b00, cnt_q} + (valid_s1 ? (CntW+2)'(2) : '0) + (CntW+2)'(2);
	assign tbl_bytes.ready = (room_need <= (CntW+2)'(FifoDepth));
	assign accept = tbl_bytes.valid && tbl_bytes.ready;

	assign results.valid   = (cnt_q != '0);
	assign results.payload = mem[rp_q];
	assign pop = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= tbl_bytes.payload;
		end
	end

	always_comb begin
		b = item_s1.table_byte;
		// apply a fresh table before this byte
		if (item_s1.first) begin
			eff_pos = '0; eff_len = '0; eff_sum = '0; eff_sig = 1'b1;
			eff_lapic = '0; eff_next = HeaderEnd; eff_ridx = '0; eff_rlen = '0;
			eff_rtype = '0; eff_rid = '0; eff_rusable = 1'b0; eff_walk = 1'b1;
			eff_ids = '0; eff_done = 1'b0;
		end else begin
			eff_pos = pos_q; eff_len = len_q; eff_sum = sum_q; eff_sig = sig_ok_q;
			eff_lapic = lapic_q; eff_next = next_off_q; eff_ridx = ridx_q;
			eff_rlen = rlen_q; eff_rtype = rtype_q; eff_rid = rid_q;
			eff_rusable = rusable_q; eff_walk = walk_q; eff_ids = ids_q;
			eff_done = done_q;
		end

		nxt_pos = eff_pos; nxt_len = eff_len; nxt_sum = eff_sum; nxt_sig = eff_sig;
		nxt_lapic = eff_lapic; nxt_next = eff_next; nxt_ridx = eff_ridx;
		nxt_rlen = eff_rlen; nxt_rtype = eff_rtype; nxt_rid = eff_rid;
		nxt_rusable = eff_rusable; nxt_walk = eff_walk; nxt_ids = eff_ids;
		nxt_done = eff_done;

		id_hit  = 1'b0;
		end_hit = 1'b0;
		rec_ok  = 1'b1;
		start33 = {1'b0, eff_next};

		if (!eff_done) begin
			nxt_sum = eff_sum + b;

			// header fields
			if (eff_pos < LenFieldBeg) begin
				if (b != SigBytes[eff_pos[1:0]]) nxt_sig = 1'b0;
			end else if (eff_pos <= LenFieldEnd) begin
				nxt_len[{eff_pos[1:0], 3'b000} +: 8] = b;
			end else if (eff_pos >= AddrFieldBeg && eff_pos < AddrFieldEnd) begin
				nxt_lapic[{eff_pos[1:0], 3'b000} +: 8] = b;
			end

			// record walk
			if (eff_walk && eff_pos >= HeaderEnd && eff_pos >= eff_next) begin
				case (eff_ridx)
					RecIdxType: begin
						if (start33 + {25'd0, MinRecord} > {1'b0, nxt_len}) begin
							nxt_walk = 1'b0;
							rec_ok   = 1'b0;
						end else begin
							nxt_rtype   = b;
							nxt_rusable = 1'b0;
						end
					end
					RecIdxLen: begin
						if (b < MinRecord || start33 + {25'd0, b} > {1'b0, nxt_len}) begin
							nxt_walk = 1'b0;
							rec_ok   = 1'b0;
						end else begin
							nxt_rlen = b;
						end
					end
					RecIdxId:    nxt_rid = b;
					RecIdxFlags: nxt_rusable = |(b[1:0] & UsableMask);
					default: ;
				endcase
				if (rec_ok) begin
					if (eff_ridx != RecIdxType &&
					    {1'b0, eff_ridx} + 9'd1 == {1'b0, nxt_rlen}) begin
						if (nxt_rtype == LapicType && nxt_rlen >= MinCpuRecord &&
						    nxt_rusable && eff_ids < MaxIds) begin
							nxt_ids = eff_ids + 9'd1;
							id_hit  = 1'b1;
						end
						nxt_next = eff_next + {24'd0, nxt_rlen};
						nxt_ridx = '0;
					end else begin
						nxt_ridx = eff_ridx + 8'd1;
					end
				end
			end

			// end of table
			if (eff_pos >= LenFieldEnd && {1'b0, eff_pos} + 33'd1 >= {1'b0, nxt_len}) begin
				end_hit  = 1'b1;
				nxt_done = 1'b1;
			end

			nxt_pos = eff_pos + 32'd1;
		end

		if (!nxt_sig)
			stat = STAT_BAD_SIG;
		else if (nxt_len < HeaderEnd)
			stat = STAT_SHORT;
		else if (nxt_sum != 8'd0)
			stat = STAT_BAD_SUM;
		else
			stat = STAT_OK;

		id_res.kind      = KIND_ID;
		id_res.apic_id   = nxt_rid;
		id_res.id_count  = nxt_ids;
		id_res.status    = STAT_OK;
		id_res.apic_base = '0;
		id_res.last      = !end_hit;

		sum_res.kind      = KIND_SUMMARY;
		sum_res.apic_id   = '0;
		sum_res.id_count  = nxt_ids;
		sum_res.status    = stat;
		sum_res.apic_base = nxt_lapic;
		sum_res.last      = 1'b1;

		res_a  = id_hit ? id_res : sum_res;
		res_b  = sum_res;
		push_n = valid_s1 ? ({1'b0, id_hit} + {1'b0, end_hit}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; len_q <= '0; sum_q <= '0; sig_ok_q <= 1'b1;
			lapic_q <= '0; next_off_q <= HeaderEnd; ridx_q <= '0; rlen_q <= '0;
			rtype_q <= '0; rid_q <= '0; rusable_q <= 1'b0; walk_q <= 1'b1;
			ids_q <= '0; done_q <= 1'b0;
		end else if (valid_s1) begin
			pos_q <= nxt_pos; len_q <= nxt_len; sum_q <= nxt_sum; sig_ok_q <= nxt_sig;
			lapic_q <= nxt_lapic; next_off_q <= nxt_next; ridx_q <= nxt_ridx;
			rlen_q <= nxt_rlen; rtype_q <= nxt_rtype; rid_q <= nxt_rid;
			rusable_q <= nxt_rusable; walk_q <= nxt_walk; ids_q <= nxt_ids;
			done_q <= nxt_done;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wp_q] <= res_a;
		end
		if (push_n == 2'd2) begin
			mem[wp_q + PtrW'(1)] <= res_b;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PtrW'(push_n);
			if (pop) rp_q <= rp_q + PtrW'(1);
			cnt_q <= cnt_q + CntW'(push_n) - CntW'(pop);
		end
	end

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q + CntW'(push_n) - CntW'(pop)) <= CntW'(FifoDepth))
		else $error("result queue overflow");

	// a finished table yields nothing until a new one starts
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && done_q && !item_s1.first |-> push_n == 2'd0)
		else $error("result after end of table");

	// an ID result always counts itself
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.payload.kind == KIND_ID |-> results.payload.id_count != '0)
		else $error("ID result with zero count");

	// two results in one step only when the second is the summary
	assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> res_a.kind == KIND_ID && res_b.kind == KIND_SUMMARY)
		else $error("bad result pair");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the MADT parser: streams tables and checks each ID and summary.
`timescale 1ns / 1ps

module tb;
	import amap_pkg::*;

	localparam logic [7:0] IoApicType = 8'd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	amap_byte_if   tbl_bytes ();
	amap_result_if results ();

	acpi_madt_apic_id_parser_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tbl_bytes (tbl_bytes),
		.results   (results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Parser state as the predictor tracks it
	logic [31:0] m_pos, m_len, m_base, m_next_rec;
	logic [7:0]  m_sum, m_rec_idx, m_rec_len, m_rec_type, m_rec_id;
	logic        m_sig_ok, m_rec_ok, m_walking, m_done;
	logic [8:0]  m_ids;

	result_item_t pending_results[$];
	logic [7:0]   tbl_q[$];

	bit          idle_on = 1'b1;
	int unsigned hold_reqs = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int          n_items = 0;
	int          n_pred = 0;
	int          n_checked = 0;
	int          n_ids_seen = 0;
	int          n_sums_seen = 0;
	int          n_err = 0;

	function automatic void clear_parse();
		m_pos = '0;
		m_len = '0;
		m_sum = '0;
		m_sig_ok = 1'b1;
		m_base = '0;
		m_next_rec = HeaderEnd;
		m_rec_idx = '0;
		m_rec_len = '0;
		m_rec_type = '0;
		m_rec_id = '0;
		m_rec_ok = 1'b0;
		m_walking = 1'b1;
		m_ids = '0;
		m_done = 1'b0;
	endfunction

	function automatic void parse_table_byte(input logic [7:0] b, input logic f);
		logic [31:0]  pos;
		logic [32:0]  start;
		logic [7:0]   idx;
		logic         ok;
		status_t      st;
		result_item_t outs [2];
		int           n;
		n = 0;
		if (f)
			clear_parse();
		if (m_done)
			return;
		pos = m_pos;
		m_sum = m_sum + b;
		if (pos < LenFieldBeg) begin
			if (b != SigBytes[pos[1:0]])
				m_sig_ok = 1'b0;
		end else if (pos <= LenFieldEnd) begin
			m_len = m_len | ({24'd0, b} << (8 * (pos - LenFieldBeg)));
		end else if (pos >= AddrFieldBeg && pos < AddrFieldEnd) begin
			m_base = m_base | ({24'd0, b} << (8 * (pos - AddrFieldBeg)));
		end

		if (m_walking && pos >= HeaderEnd && pos >= m_next_rec) begin
			start = {1'b0, m_next_rec};
			idx = m_rec_idx;
			ok = 1'b1;
			if (idx == RecIdxType) begin
				if (start + MinRecord > {1'b0, m_len}) begin
					m_walking = 1'b0;
					ok = 1'b0;
				end else begin
					m_rec_type = b;
					m_rec_ok = 1'b0;
				end
			end else if (idx == RecIdxLen) begin
				if (b < MinRecord || start + b > {1'b0, m_len}) begin
					m_walking = 1'b0;
					ok = 1'b0;
				end else begin
					m_rec_len = b;
				end
			end else if (idx == RecIdxId) begin
				m_rec_id = b;
			end else if (idx == RecIdxFlags) begin
				m_rec_ok = (b[1:0] & UsableMask) != 2'b00;
			end
			if (ok) begin
				if (idx >= RecIdxLen && {1'b0, idx} + 9'd1 == {1'b0, m_rec_len}) begin
					if (m_rec_type == LapicType && m_rec_len >= MinCpuRecord && m_rec_ok &&
					    m_ids < MaxIds) begin
						m_ids = m_ids + 9'd1;
						outs[n] = '{KIND_ID, m_rec_id, m_ids, STAT_OK, 32'd0, 1'b0};
						n++;
					end
					m_next_rec = start[31:0] + {24'd0, m_rec_len};
					m_rec_idx = '0;
				end else begin
					m_rec_idx = idx + 8'd1;
				end
			end
		end

		if (pos >= LenFieldEnd && {1'b0, pos} + 33'd1 >= {1'b0, m_len}) begin
			if (!m_sig_ok)
				st = STAT_BAD_SIG;
			else if (m_len < HeaderEnd)
				st = STAT_SHORT;
			else if (m_sum != 8'd0)
				st = STAT_BAD_SUM;
			else
				st = STAT_OK;
			outs[n] = '{KIND_SUMMARY, 8'd0, m_ids, st, m_base, 1'b0};
			n++;
			m_done = 1'b1;
		end

		m_pos = pos + 32'd1;
		if (n > 0)
			outs[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.push_back(outs[i]);
		n_pred += n;
	endfunction

	function automatic string fmt(input result_item_t r);
		return $sformatf("kind=%0d id=%0d count=%0d status=%0d base=%h last=%0d",
			r.kind, r.apic_id, r.id_count, r.status, r.apic_base, r.last);
	endfunction

	task automatic note_error(input string msg);
		n_err++;
		if (n_err <= 10)
			$display("%0t ERROR %s", $time, msg);
	endtask

	function automatic logic [7:0] rand_flags();
		return ($urandom_range(3) != 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
	endfunction

	// Table image: random header bytes with the signature and APIC address in place
	task automatic open_table(input logic [31:0] base);
		tbl_q.delete();
		for (int i = 0; i < HeaderEnd; i++)
			tbl_q.push_back(8'($urandom_range(255)));
		for (int i = 0; i < 4; i++) begin
			tbl_q[i] = SigBytes[i];
			tbl_q[AddrFieldBeg + i] = base[8 * i +: 8];
		end
	endtask

	task automatic add_rec(input logic [7:0] rtype, input logic [7:0] rlen,
	                       input logic [7:0] rid, input logic [7:0] rflags);
		int at;
		int n;
		at = tbl_q.size();
		n = (rlen < MinRecord) ? MinRecord : rlen;
		for (int i = 0; i < n; i++)
			tbl_q.push_back(8'($urandom_range(255)));
		tbl_q[at] = rtype;
		tbl_q[at + 1] = rlen;
		if (rlen > RecIdxId)
			tbl_q[at + 3] = rid;
		if (rlen > RecIdxFlags)
			tbl_q[at + 4] = rflags;
	endtask

	// Write the length field and fix the checksum byte over the bytes that count
	task automatic close_table(input logic [31:0] len);
		logic [7:0] acc;
		int stop;
		for (int i = 0; i < 4; i++)
			tbl_q[LenFieldBeg + i] = len[8 * i +: 8];
		if (len <= LenFieldEnd)
			stop = LenFieldEnd + 1;
		else if (len > tbl_q.size())
			stop = tbl_q.size();
		else
			stop = len;
		acc = 8'd0;
		for (int i = 0; i < stop; i++)
			if (i != 9)
				acc = acc + tbl_q[i];
		tbl_q[9] = 8'd0 - acc;
	endtask

	// Leaves valid high after the transfer; the next call or the caller drops it
	task automatic send_byte(input logic [7:0] b, input logic f);
		while (idle_on && $urandom_range(99) < 28) begin
			tbl_bytes.valid <= 1'b0;
			@(posedge clk);
		end
		tbl_bytes.valid <= 1'b1;
		tbl_bytes.payload <= '{table_byte: b, first: f};
		@(posedge clk);
		while (!tbl_bytes.ready)
			@(posedge clk);
		parse_table_byte(b, f);
		n_items++;
	endtask

	task automatic send_table(input logic f);
		for (int i = 0; i < tbl_q.size(); i++)
			send_byte(tbl_q[i], (i == 0) ? f : 1'b0);
	endtask

	// Fresh state after reset, usable and unusable records, bytes after the end
	task automatic test_reset_state();
		open_table(32'hFFFF_FFFF);
		add_rec(LapicType, MinCpuRecord, 8'd0, 8'h01);
		add_rec(LapicType, MinCpuRecord, 8'd255, 8'h02);
		add_rec(LapicType, MinCpuRecord, 8'd7, 8'h00);
		add_rec(LapicType, MinCpuRecord, 8'd8, 8'hFC);
		add_rec(IoApicType, 8'd12, 8'd9, 8'hFF);
		add_rec(LapicType, 8'd6, 8'd10, 8'h03);
		add_rec(LapicType, MinCpuRecord, 8'd11, 8'hFF);
		close_table(tbl_q.size());
		send_table(1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_header_status();
		// bad signature wins over short length and bad checksum
		open_table(32'h1234_5678);
		tbl_q[2] ^= 8'h80;
		close_table(32'd30);
		tbl_q[9] ^= 8'h01;
		send_table(1'b1);
		open_table(32'h0);
		close_table(32'd20);
		tbl_q[9] ^= 8'h01;
		send_table(1'b1);
		// lengths under 8 end the table at the last length byte
		open_table(32'h0);
		close_table(32'd0);
		send_table(1'b1);
		open_table(32'h0);
		close_table(32'd5);
		send_table(1'b1);
		open_table(32'hFFFF_FFFF);
		close_table(HeaderEnd);
		tbl_q[9] ^= 8'h40;
		send_table(1'b1);
		open_table(32'h0);
		close_table(HeaderEnd);
		send_table(1'b1);
		// a length never reached: the next first byte cuts the table off
		open_table(32'hA5A5_5A5A);
		close_table(32'hFFFF_FFFF);
		send_table(1'b1);
	endtask

	task automatic test_record_walk();
		// record length below two stops the walk
		open_table(32'hFEE0_0000);
		add_rec(LapicType, 8'd1, 8'd0, 8'd0);
		add_rec(LapicType, MinCpuRecord, 8'd3, 8'h01);
		close_table(tbl_q.size());
		send_table(1'b1);
		// record running past the table end
		open_table(32'hFEE0_0000);
		add_rec(LapicType, MinCpuRecord, 8'd5, 8'h01);
		add_rec(LapicType, 8'd20, 8'd6, 8'h01);
		close_table(tbl_q.size() - 4);
		send_table(1'b1);
		// a lone byte left where a record would start
		open_table(32'hFEE0_0000);
		add_rec(LapicType, MinCpuRecord, 8'd9, 8'h03);
		tbl_q.push_back(8'h00);
		close_table(tbl_q.size());
		send_table(1'b1);
		// longest record, shortest records, a record with flags but too short
		open_table(32'h8000_0001);
		add_rec(LapicType, 8'd255, 8'd200, 8'h01);
		add_rec(LapicType, MinRecord, 8'd0, 8'd0);
		add_rec(LapicType, 8'd4, 8'd0, 8'd0);
		add_rec(LapicType, 8'd5, 8'd1, 8'h01);
		add_rec(LapicType, MinCpuRecord, 8'd2, 8'h02);
		close_table(tbl_q.size());
		send_table(1'b1);
	endtask

	// More usable records than the ID limit, with no idling on either side
	task automatic test_id_limit();
		idle_on = 1'b0;
		open_table(32'hFEE0_0000);
		repeat (MaxIds + 4)
			add_rec(LapicType, MinCpuRecord, 8'($urandom_range(255)), 8'h01);
		close_table(tbl_q.size());
		send_table(1'b1);
		idle_on = 1'b1;
	endtask

	// Hold off the result side while bytes keep coming so the input stalls
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_reqs <= hold_reqs + 1;
		open_table(32'hFEC0_0000);
		repeat (30)
			add_rec(LapicType, MinCpuRecord, 8'($urandom_range(255)), rand_flags());
		close_table(tbl_q.size());
		send_table(1'b1);
		idle_on = 1'b1;
	endtask

	task automatic test_random_tables();
		int item_mark;
		int res_mark;
		int mode;
		int pick;
		int n;
		item_mark = n_items;
		res_mark = n_pred;
		while (n_items - item_mark < 550 || n_pred - res_mark < 48) begin
			mode = $urandom_range(99);
			if (mode >= 93) begin
				// noise, with first raised at random inside it
				n = $urandom_range(10, 60);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom_range(255)), (i == 0) || ($urandom_range(15) == 0));
			end else begin
				open_table($urandom());
				repeat ($urandom_range(6)) begin
					pick = $urandom_range(99);
					if (pick < 55)
						add_rec(LapicType, MinCpuRecord, 8'($urandom_range(255)), rand_flags());
					else if (pick < 65)
						add_rec(LapicType, 8'($urandom_range(2, 16)), 8'($urandom_range(255)),
							rand_flags());
					else if (pick < 85)
						add_rec(8'($urandom_range(1, 255)), 8'($urandom_range(2, 20)),
							8'($urandom_range(255)), rand_flags());
					else if (pick < 95)
						add_rec(LapicType, 8'($urandom_range(8, 40)), 8'($urandom_range(255)),
							rand_flags());
					else
						add_rec(8'($urandom_range(255)), 8'($urandom_range(1)),
							8'($urandom_range(255)), rand_flags());
				end
				if (mode < 65) begin
					close_table(tbl_q.size());
				end else if (mode < 73) begin
					close_table(tbl_q.size());
					tbl_q[9] ^= 8'($urandom_range(1, 255));
				end else if (mode < 79) begin
					close_table(tbl_q.size());
					tbl_q[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
				end else if (mode < 85) begin
					close_table($urandom_range(HeaderEnd - 1));
				end else begin
					close_table(tbl_q.size() - $urandom_range(1, 12));
				end
				send_table(1'b1);
				if ($urandom_range(4) == 0)
					repeat ($urandom_range(1, 4))
						send_byte(8'($urandom_range(255)), 1'b0);
			end
		end
	endtask

	// Receiver hold-off, one long stretch per request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_reqs) begin
			hold_left <= 300;
			hold_served <= hold_served + 1;
		end
	end

	// Result side: check each transfer against the oldest expectation, then drive ready
	initial begin
		result_item_t got;
		result_item_t want;
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (results.valid && results.ready) begin
				got = results.payload;
				n_checked++;
				if (got.kind == KIND_SUMMARY)
					n_sums_seen++;
				else
					n_ids_seen++;
				if (pending_results.size() == 0) begin
					note_error({"result with none expected: ", fmt(got)});
				end else begin
					want = pending_results.pop_front();
					if (got.kind !== want.kind || got.apic_id !== want.apic_id ||
					    got.id_count !== want.id_count || got.status !== want.status ||
					    got.apic_base !== want.apic_base || got.last !== want.last)
						note_error({"mismatch: expected ", fmt(want), " got ", fmt(got)});
				end
			end
			results.ready <= (hold_left == 0) && (!idle_on || $urandom_range(99) >= 28);
		end
	end

	initial begin
		int guard;
		tbl_bytes.valid = 1'b0;
		tbl_bytes.payload = '0;
		clear_parse();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_header_status();
		test_record_walk();
		test_id_limit();
		test_backpressure();
		test_random_tables();

		tbl_bytes.valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			note_error($sformatf("%0d expected results never arrived", pending_results.size()));

		$display("covered %0d table bytes: header status cases, record walk stops, ID limit,",
			n_items);
		$display("receiver hold-off; %0d results checked (%0d IDs, %0d summaries), %0d errors",
			n_checked, n_ids_seen, n_sums_seen, n_err);
		if (n_err == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout waiting for the parser");
		$display("status: fail");
		$finish;
	end

endmodule
